// ----- hw/rtl/htd_pkg.sv -----
// Shared types and constants for the Huffman tree decoder.
// Transaction structs, node table entry, operation codes, controller states.
// No dependencies.
package htd_pkg;

   localparam int CHILD_W = 9;
   localparam int SYM_W   = 8;
   localparam int IDX_W   = 8;
   localparam int BYTE_W  = 8;
   localparam int OP_W    = 2;
   localparam int CNT_W   = 32;
   localparam int BIT_W   = 3;

   localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_W-1:0] OP_DECODE  = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [IDX_W-1:0]   node_index;
      logic [CHILD_W-1:0] left_child;
      logic [CHILD_W-1:0] right_child;
      logic [BYTE_W-1:0]  code_byte;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
      logic             done_res;
   } rsp_type;

   typedef struct packed {
      logic [CHILD_W-1:0] right_child;
      logic [CHILD_W-1:0] left_child;
   } node_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } dec_state_type;

endpackage

// ----- hw/rtl/huffman_tree_decoder_unit.sv -----
// Huffman tree-walk decoder: node table memory, bit-serial walk, result register.
// Depends on htd_pkg.
//
// Usage:
//   req_ channel (valid/ready) carries load, decode and restart transactions.
//   A load writes one internal node of the code tree; a restart sends the walk
//   back to the root and clears the emitted-symbol count; a decode transaction
//   carries one code byte, walked MSB first.
//   rsp_ channel (valid/ready) returns one transaction per decoded symbol, with
//   last set on the final symbol of a code byte and done_res on the symbol
//   that reaches csr_ symbol_count. Later code bytes give no results.
//   csr_we/csr_wdata write symbol_count; write it only while the block is idle.
// Operation:
//   Load and restart leave the block idle. A decode walks with one table read
//   per code bit (the read port closes the loop), stopping early at the symbol
//   that reaches symbol_count, then flushes; only idle accepts the next request.
//   A symbol enters the result register at the next leaf or in the flush state.
// Reset puts the walk at the root and clears the counters; the node table
//   keeps no reset and must be loaded before decoding.
// A stalled receiver holds the walk at the bit that produces the next symbol.
module huffman_tree_decoder_unit #(
   parameter int SYMBOLS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  htd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output htd_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [htd_pkg::CNT_W-1:0] csr_wdata
);

   localparam int DEPTH   = SYMBOLS - 1;
   localparam int NODE_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [htd_pkg::CHILD_W-1:0] ROOT    = htd_pkg::CHILD_W'(2 * SYMBOLS - 2);
   localparam logic [htd_pkg::CHILD_W-1:0] SYM_LIM = htd_pkg::CHILD_W'(SYMBOLS);
   localparam logic [htd_pkg::IDX_W-1:0]   IDX_LIM = htd_pkg::IDX_W'(DEPTH);

   htd_pkg::node_type tree_mem [DEPTH];
   htd_pkg::node_type rd_data_ff;
   logic [NODE_AW-1:0] rd_addr;

   htd_pkg::dec_state_type state_ff, state_in;
   logic [htd_pkg::CHILD_W-1:0] node_ff, node_in;
   logic [htd_pkg::CNT_W-1:0]   emitted_ff, emitted_in;
   logic [htd_pkg::CNT_W-1:0]   count_ff;
   logic [htd_pkg::BYTE_W-1:0]  byte_ff, byte_in;
   logic [htd_pkg::BIT_W-1:0]   bit_ff, bit_in;
   logic                        pend_valid_ff, pend_valid_in;
   logic [htd_pkg::SYM_W-1:0]   pend_sym_ff, pend_sym_in;
   logic                        pend_done_ff, pend_done_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   htd_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                        accept, mem_we, out_load, out_busy;
   logic [htd_pkg::CHILD_W-1:0] next_node, addr_node, slot_diff;
   logic [htd_pkg::CNT_W-1:0]   emitted_inc;
   logic                        is_leaf, is_bad, hit_done;

   assign req_ready = (state_ff == htd_pkg::ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_busy  = rsp_valid_ff & ~rsp_ready;

   assign mem_we = accept & (req_data.operation == htd_pkg::OP_LOAD)
                   & (req_data.node_index < IDX_LIM);

   assign next_node   = byte_ff[htd_pkg::BYTE_W-1] ? rd_data_ff.right_child
                                                   : rd_data_ff.left_child;
   assign is_leaf     = next_node < SYM_LIM;
   assign is_bad      = next_node > ROOT;
   assign emitted_inc = emitted_ff + htd_pkg::CNT_W'(1);
   assign hit_done    = (emitted_inc == count_ff);

   assign slot_diff = addr_node - SYM_LIM;
   assign rd_addr   = slot_diff[NODE_AW-1:0];

   always_comb begin
      state_in      = state_ff;
      node_in       = node_ff;
      emitted_in    = emitted_ff;
      byte_in       = byte_ff;
      bit_in        = bit_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      pend_done_in  = pend_done_ff;
      out_load      = 1'b0;
      rsp_data_in   = rsp_data_ff;
      addr_node     = node_ff;
      unique case (state_ff)
         htd_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.operation == htd_pkg::OP_RESTART) begin
                  node_in    = ROOT;
                  emitted_in = '0;
               end else if (req_data.operation == htd_pkg::OP_DECODE
                            && emitted_ff < count_ff) begin
                  byte_in  = req_data.code_byte;
                  bit_in   = '0;
                  state_in = htd_pkg::ST_WALK;
               end
            end
         end
         htd_pkg::ST_WALK: begin
            if (!(is_leaf && pend_valid_ff && out_busy)) begin
               byte_in = {byte_ff[htd_pkg::BYTE_W-2:0], 1'b0};
               bit_in  = bit_ff + htd_pkg::BIT_W'(1);
               if (is_leaf) begin
                  if (pend_valid_ff) begin
                     out_load    = 1'b1;
                     rsp_data_in = '{symbol: pend_sym_ff, last: 1'b0, done_res: pend_done_ff};
                  end
                  pend_valid_in = 1'b1;
                  pend_sym_in   = next_node[htd_pkg::SYM_W-1:0];
                  pend_done_in  = hit_done;
                  emitted_in    = emitted_inc;
                  node_in       = ROOT;
               end else if (is_bad) begin
                  node_in = ROOT;
               end else begin
                  node_in = next_node;
               end
               addr_node = node_in;
               if ((is_leaf && hit_done) || bit_ff == '1) begin
                  state_in = htd_pkg::ST_FLUSH;
               end
            end
         end
         htd_pkg::ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = htd_pkg::ST_IDLE;
            end else if (!out_busy) begin
               out_load      = 1'b1;
               rsp_data_in   = '{symbol: pend_sym_ff, last: 1'b1, done_res: pend_done_ff};
               pend_valid_in = 1'b0;
               state_in      = htd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = htd_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = out_load | out_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= htd_pkg::ST_IDLE;
         node_ff       <= ROOT;
         emitted_ff    <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_ff       <= node_in;
         emitted_ff    <= emitted_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      bit_ff       <= bit_in;
      pend_sym_ff  <= pend_sym_in;
      pend_done_ff <= pend_done_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tree_mem[req_data.node_index[NODE_AW-1:0]] <= '{right_child: req_data.right_child,
                                                         left_child:  req_data.left_child};
      end
      rd_data_ff <= tree_mem[rd_addr];
   end

endmodule
